// ----- src/random_probe_bitmap_id_allocator_macros.svh -----
// Assertion helpers for the allocator module.
`ifndef RANDOM_PROBE_BITMAP_ID_ALLOCATOR_MACROS_SVH
`define RANDOM_PROBE_BITMAP_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPBIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPBIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- src/rpbia_pkg.sv -----
package rpbia_pkg;

    localparam int ID_W = 10;
    localparam int SEED_W = 16;
    // Every id that the request field can name lies below this bound.
    localparam int ID_SPACE = 1024;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [SEED_W-1:0] LFSR_RESET = 16'h0001;
    // Index of the last draw in one full LFSR period.
    localparam logic [SEED_W-1:0] LFSR_LAST_TRY = 16'hFFFE;

    typedef enum logic [1:0] {
        ACT_PROPOSE = 2'd0,
        ACT_MARK    = 2'd1,
        ACT_UNMARK  = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    typedef struct packed {
        t_action          action;
        logic [ID_W-1:0]  target_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]  granted_id;
        logic [ID_W-1:0]  used_count;
    } t_rsp;

    // Galois LFSR, shifting right.
    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] cur);
        logic [SEED_W-1:0] nxt;
        nxt = cur >> 1;
        if (cur[0]) begin
            nxt = nxt ^ LFSR_TAPS;
        end
        return nxt;
    endfunction

endpackage

// ----- src/random_probe_bitmap_id_allocator.sv -----
// Random-probe slot id allocator over a bitmap of used flags.
// Requests arrive on the input channel (i_in_valid / o_in_ready / i_in_data) and each
// request yields exactly one response transfer on the output channel
// (o_out_valid / i_out_ready / o_out_data) carrying the granted id and the used count.
// Propose answers a free id without marking it; mark and unmark flip one flag and
// the count follows only real changes; clear empties the whole bitmap.
// A single shared 16x32 multiplier, driven by a small sequencer, does every division
// by a constant (candidate modulo MAX_ID+1, id split into page and bit).
// Clear goes straight to the response, as do mark and unmark of an id that is zero or
// out of range; others split the id into page and bit, read the row and update it.
// Propose draws a candidate modulo MAX_ID+1, checks it likewise, takes it if free, else
// scans its page; a zero or out-of-store candidate, or a full page, leads to a new draw.
// A full store answers a propose without drawing. One request is worked on at a time,
// and the next transfer can come the cycle after a request reaches the output register.
// If the receiver stalls, the response sits in the output register; the block still
// takes the next request, but that one holds in its last step until the register drains.
// i_cfg_we writes the seed of the draw register (zero counts as one) and reloads it.
// Reset (synchronous, active low) empties the bitmap, zeroes the count and loads the
// draw register with one. No clearing pass is needed, since each bitmap row has a
// valid flag that reset and clear drop at once.
`include "random_probe_bitmap_id_allocator_macros.svh"

module random_probe_bitmap_id_allocator #(
    parameter int MAX_ID     = 1023,
    parameter int PAGE_BITS  = 64,
    parameter int PAGE_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rpbia_pkg::SEED_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rpbia_pkg::t_req               i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rpbia_pkg::t_rsp               o_out_data
);

    import rpbia_pkg::*;

    // Only pages that hold an id below ID_SPACE can ever be marked, so only those
    // pages are stored; every other page always reads as free.
    localparam int REACH  = (ID_SPACE + PAGE_BITS - 1) / PAGE_BITS;
    localparam int ROWS   = (PAGE_COUNT < REACH) ? PAGE_COUNT : REACH;
    localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BW     = $clog2(PAGE_BITS);
    localparam logic [16:0] MOD_D    = 17'(MAX_ID + 1);
    localparam logic [16:0] MAX_V    = 17'(MAX_ID);
    localparam logic [16:0] ID_LIMIT = 17'(PAGE_COUNT * PAGE_BITS);
    localparam logic [15:0] PB_V     = 16'(PAGE_BITS);
    localparam logic [15:0] ROWS_V   = 16'(ROWS);
    // Reciprocals for division by a constant: the quotient is low by at most one.
    localparam logic [31:0] RECIP_D  = 32'((64'd1 << 32) / (MAX_ID + 1));
    localparam logic [31:0] RECIP_P  = 32'((64'd1 << 32) / PAGE_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAW,
        S_MODQ,
        S_MODR,
        S_PGM,
        S_PGQ,
        S_PGR,
        S_RD,
        S_CHK,
        S_FIND,
        S_OUT
    } t_state;

    t_state                r_state;
    t_action               r_op;
    logic [SEED_W-1:0]     r_lfsr;
    logic [SEED_W-1:0]     r_tries;
    logic [ID_W-1:0]       r_used;
    logic [15:0]           r_cand;
    logic [15:0]           r_page;
    logic [BW-1:0]         r_bit;
    logic [15:0]           r_grant;
    logic [PAGE_BITS-1:0]  r_vmask;
    logic [PAGE_BITS-1:0]  r_free;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [15:0]           mul_a;
    logic [31:0]           mul_b;
    logic [47:0]           mul_p;
    logic [SEED_W-1:0]     lfsr_adv;
    logic [16:0]           mod_diff;
    logic [16:0]           mod_rem;
    logic [15:0]           bit_diff;
    logic [15:0]           base_id;
    logic [16:0]           lim;
    logic [PAGE_BITS-1:0]  vmask;
    logic [PAGE_BITS-1:0]  low_free;
    logic [BW-1:0]         low_idx;
    logic [PAGE_BITS-1:0]  row;
    logic                  was_used;
    logic                  tries_done;
    logic                  in_xfer;
    logic                  target_ok;
    logic                  rd_en;
    logic                  wr_en;
    logic [PAGE_BITS-1:0]  wr_data;
    logic                  clr;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign lfsr_adv   = lfsr_next(r_lfsr);
    assign tries_done = (r_tries == LFSR_LAST_TRY);
    assign target_ok  = (i_in_data.target_id != '0) &&
                        (17'(i_in_data.target_id) <= MAX_V) &&
                        (17'(i_in_data.target_id) < ID_LIMIT);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = r_cand;
        mul_b = RECIP_P;
        case (r_state)
            S_DRAW: begin
                mul_a = lfsr_adv;
                mul_b = RECIP_D;
            end
            S_MODQ: begin
                mul_a = mul_p[47:32];
                mul_b = 32'(MOD_D);
            end
            S_PGQ: begin
                mul_a = mul_p[47:32];
                mul_b = 32'(PB_V);
            end
            default: begin
                mul_a = r_cand;
                mul_b = RECIP_P;
            end
        endcase
    end

    rpbia_mul #(
        .A_W (16),
        .B_W (32)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Remainder of the draw and of the page split, each corrected once.
    always_comb begin
        mod_diff = {1'b0, r_lfsr} - mul_p[16:0];
        mod_rem  = (mod_diff >= MOD_D) ? (mod_diff - MOD_D) : mod_diff;
        bit_diff = r_cand - mul_p[15:0];
        base_id  = r_cand - 16'(r_bit);
        lim      = MAX_V - {1'b0, base_id};
    end

    // Bits of the page that hold a valid id: not id zero and not above MAX_ID.
    always_comb begin
        for (int b = 0; b < PAGE_BITS; b++) begin
            vmask[b] = (17'(b) <= lim) && ((b != 0) || (base_id != '0));
        end
    end

    // Lowest free valid bit of the page.
    always_comb begin
        low_free = r_free & (~r_free + {{(PAGE_BITS-1){1'b0}}, 1'b1});
        low_idx  = '0;
        for (int b = 0; b < PAGE_BITS; b++) begin
            low_idx = low_idx | (low_free[b] ? BW'(b) : '0);
        end
    end

    assign was_used = row[r_bit];

    always_comb begin
        rd_en   = (r_state == S_RD);
        clr     = in_xfer && (i_in_data.action == ACT_CLEAR);
        wr_en   = 1'b0;
        wr_data = row;
        if (r_state == S_CHK) begin
            if (r_op == ACT_MARK && !was_used) begin
                wr_en   = 1'b1;
                wr_data = row | (PAGE_BITS'(1) << r_bit);
            end else if (r_op == ACT_UNMARK && was_used) begin
                wr_en   = 1'b1;
                wr_data = row & ~(PAGE_BITS'(1) << r_bit);
            end
        end
    end

    rpbia_store #(
        .ROWS     (ROWS),
        .ROW_BITS (PAGE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (clr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_page[AW-1:0]),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_page[AW-1:0]),
        .i_wr_data (wr_data),
        .o_rd_data (row)
    );

    // Sequencer: one request at a time, at most one multiplier step per state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= ACT_PROPOSE;
            r_lfsr      <= LFSR_RESET;
            r_tries     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_lfsr <= (i_cfg_wdata == '0) ? LFSR_RESET : i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op    <= i_in_data.action;
                        r_cand  <= 16'(i_in_data.target_id);
                        r_tries <= '0;
                        r_grant <= '0;
                        case (i_in_data.action)
                            ACT_PROPOSE: begin
                                if (17'(r_used) >= MAX_V) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_DRAW;
                                end
                            end
                            ACT_MARK, ACT_UNMARK: begin
                                r_state <= target_ok ? S_PGM : S_OUT;
                            end
                            default: begin
                                r_used  <= '0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DRAW: begin
                    r_lfsr  <= lfsr_adv;
                    r_state <= S_MODQ;
                end
                S_MODQ: begin
                    r_state <= S_MODR;
                end
                S_MODR: begin
                    r_cand <= mod_rem[15:0];
                    if ((mod_rem != '0) && (mod_rem < ID_LIMIT)) begin
                        r_state <= S_PGM;
                    end else if (tries_done) begin
                        r_grant <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_tries <= r_tries + 1'b1;
                        r_state <= S_DRAW;
                    end
                end
                S_PGM: begin
                    r_state <= S_PGQ;
                end
                S_PGQ: begin
                    r_page  <= mul_p[47:32];
                    r_state <= S_PGR;
                end
                S_PGR: begin
                    if (bit_diff >= PB_V) begin
                        r_bit  <= BW'(bit_diff - PB_V);
                        r_page <= r_page + 1'b1;
                    end else begin
                        r_bit  <= BW'(bit_diff);
                    end
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_vmask <= vmask;
                    // Pages beyond the stored rows are never marked.
                    if (r_page >= ROWS_V) begin
                        r_grant <= r_cand;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_op == ACT_PROPOSE) begin
                        if (!was_used) begin
                            r_grant <= r_cand;
                            r_state <= S_OUT;
                        end else begin
                            r_free  <= ~row & r_vmask;
                            r_state <= S_FIND;
                        end
                    end else begin
                        if (r_op == ACT_MARK && !was_used) begin
                            r_used <= r_used + 1'b1;
                        end else if (r_op == ACT_UNMARK && was_used) begin
                            r_used <= r_used - 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_FIND: begin
                    if (r_free != '0) begin
                        r_grant <= base_id + 16'(low_idx);
                        r_state <= S_OUT;
                    end else if (tries_done) begin
                        r_grant <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_tries <= r_tries + 1'b1;
                        r_state <= S_DRAW;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid      <= 1'b1;
                        r_out.granted_id <= r_grant[ID_W-1:0];
                        r_out.used_count <= r_used;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The count can never pass the number of valid ids.
    `RPBIA_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, 17'(r_used) <= MAX_V)
    // A clear empties the count in the very next cycle.
    `RPBIA_ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, clr, r_used == '0)
    // The count only moves on a clear transfer or in the update step.
    `RPBIA_ASSERT_NEXT(a_used_still, i_clk, i_rst_n, (r_state != S_CHK) && !clr,
                       $stable(r_used))
    // The draw register never locks up at zero.
    `RPBIA_ASSERT_IMPL(a_lfsr_live, i_clk, i_rst_n, 1'b1, r_lfsr != '0)

endmodule

// ----- src/rpbia_mul.sv -----
module rpbia_mul #(
    parameter int A_W = 16,
    parameter int B_W = 32
) (
    input  logic                 i_clk,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [A_W+B_W-1:0]   o_p
);

    logic [A_W+B_W-1:0] r_p;

    // The product is registered; the sequencer reads it in the next cycle.
    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- src/rpbia_store.sv -----
module rpbia_store #(
    parameter int ROWS     = 16,
    parameter int ROW_BITS = 64,
    localparam int AW      = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [ROW_BITS-1:0]  i_wr_data,
    output logic [ROW_BITS-1:0]  o_rd_data
);

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROWS-1:0]     r_valid;
    logic [ROW_BITS-1:0] r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // A row that was not written since reset or the last clear reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rpbia_pkg::*;

    // The block is built with its default geometry: ids 1..1023 in 16 pages of 64 flags.
    localparam int MAX_ID     = 1023;
    localparam int PAGE_BITS  = 64;
    localparam int PAGE_COUNT = 16;

    // One full LFSR period bounds the search of a single propose.
    localparam int DRAW_LIMIT = 65535;

    // Cycles without any transfer before the run is declared hung. The limit has to cover a
    // propose that walks a whole LFSR period.
    localparam int QUIET_LIMIT = 3000000;

    // Cycles to watch the output after the last expected response has arrived.
    localparam int TAIL_CYCLES = 24;

    localparam int DIR_ROWS = 20;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [SEED_W-1:0] cfg_wdata = '0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    t_req            in_data = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    t_rsp            out_data;

    // Percent chance per cycle that the sender holds back or the receiver stalls.
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    int              fail_count = 0;
    int              quiet_cycles = 0;

    // Responses predicted for accepted requests, oldest first.
    t_rsp            rsp_due[$];

    // Shadow of the allocator state.
    bit              used_flag [ID_SPACE];
    int unsigned     used_total = 0;
    logic [SEED_W-1:0] draw_reg = LFSR_RESET;

    // Last id that a propose handed out, and ids the stimulus has allocated.
    logic [ID_W-1:0] last_grant = '0;
    int              held_ids[$];

    // One row of the directed stimulus. When reseed is set, the seed register is
    // written before the request goes out. When typed is set, want holds the
    // expected response as read straight off the behavior; otherwise the shadow
    // allocator supplies it.
    typedef struct packed {
        logic              reseed;
        logic [SEED_W-1:0] seed;
        t_action           action;
        logic [ID_W-1:0]   target_id;
        logic              typed;
        t_rsp              want;
    } t_dir_row;

    // Columns: reseed, seed, action, target_id, typed, {granted_id, used_count}.
    t_dir_row dir_rows [DIR_ROWS] = '{
        // First draw after reset lands on candidate 0, which is never handed out.
        '{1'b0, 16'h0000, ACT_PROPOSE, 10'd0,    1'b0, '{10'd0, 10'd0}},
        '{1'b0, 16'h0000, ACT_MARK,    10'd512,  1'b1, '{10'd0, 10'd1}},
        // Replaying the same draws hits a used candidate, so the page scan answers.
        '{1'b1, 16'h0001, ACT_PROPOSE, 10'd1023, 1'b0, '{10'd0, 10'd0}},
        // Id 0 is never a valid id: mark and unmark leave everything alone.
        '{1'b0, 16'h0000, ACT_MARK,    10'd0,    1'b1, '{10'd0, 10'd1}},
        '{1'b0, 16'h0000, ACT_UNMARK,  10'd0,    1'b1, '{10'd0, 10'd1}},
        // The count only follows real flag changes.
        '{1'b0, 16'h0000, ACT_MARK,    10'd512,  1'b1, '{10'd0, 10'd1}},
        '{1'b0, 16'h0000, ACT_UNMARK,  10'd700,  1'b1, '{10'd0, 10'd1}},
        '{1'b0, 16'h0000, ACT_MARK,    10'd1023, 1'b1, '{10'd0, 10'd2}},
        '{1'b0, 16'h0000, ACT_MARK,    10'd1,    1'b1, '{10'd0, 10'd3}},
        '{1'b0, 16'h0000, ACT_PROPOSE, 10'd341,  1'b0, '{10'd0, 10'd0}},
        '{1'b0, 16'h0000, ACT_UNMARK,  10'd1023, 1'b1, '{10'd0, 10'd2}},
        '{1'b0, 16'h0000, ACT_CLEAR,   10'd1023, 1'b1, '{10'd0, 10'd0}},
        // Clear keeps the draw register, so this propose continues the sequence.
        '{1'b0, 16'h0000, ACT_PROPOSE, 10'd682,  1'b0, '{10'd0, 10'd0}},
        '{1'b0, 16'h0000, ACT_UNMARK,  10'd1,    1'b1, '{10'd0, 10'd0}},
        // Last id of page 0 and first id of page 1.
        '{1'b0, 16'h0000, ACT_MARK,    10'd63,   1'b1, '{10'd0, 10'd1}},
        '{1'b0, 16'h0000, ACT_MARK,    10'd64,   1'b1, '{10'd0, 10'd2}},
        '{1'b0, 16'h0000, ACT_CLEAR,   10'd0,    1'b1, '{10'd0, 10'd0}},
        // Largest seed, then a zero seed, which the block treats as one.
        '{1'b1, 16'hFFFF, ACT_PROPOSE, 10'd0,    1'b0, '{10'd0, 10'd0}},
        '{1'b1, 16'h0000, ACT_PROPOSE, 10'd0,    1'b0, '{10'd0, 10'd0}},
        '{1'b0, 16'h0000, ACT_CLEAR,   10'd0,    1'b1, '{10'd0, 10'd0}}
    };

    random_probe_bitmap_id_allocator #(
        .MAX_ID     (MAX_ID),
        .PAGE_BITS  (PAGE_BITS),
        .PAGE_COUNT (PAGE_COUNT)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver decides once per cycle, at the falling edge, whether it stalls.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // An id is usable when it is nonzero, within MAX_ID, and inside the store.
    function automatic bit id_ok(input int unsigned id);
        return id >= 1 && id <= MAX_ID && id < PAGE_COUNT * PAGE_BITS;
    endfunction

    // Galois step of the draw register: shift right, fold the taps in when a one
    // falls out of the bottom.
    function automatic logic [SEED_W-1:0] draw_step(input logic [SEED_W-1:0] r);
        return r[0] ? ((r >> 1) ^ LFSR_TAPS) : (r >> 1);
    endfunction

    // Search for a free id the way propose does: draw a candidate, take it if free,
    // otherwise take the lowest free id of its page, otherwise draw again.
    function automatic logic [ID_W-1:0] find_free_id();
        int unsigned cand;
        int unsigned page_base;
        int unsigned tries;
        int unsigned b;
        if (used_total >= MAX_ID) begin
            return '0;
        end
        for (tries = 0; tries < DRAW_LIMIT; tries++) begin
            draw_reg = draw_step(draw_reg);
            cand = draw_reg % (MAX_ID + 1);
            if (id_ok(cand)) begin
                if (!used_flag[cand]) begin
                    return ID_W'(cand);
                end
                page_base = (cand / PAGE_BITS) * PAGE_BITS;
                for (b = 0; b < PAGE_BITS; b++) begin
                    if (id_ok(page_base + b) && !used_flag[page_base + b]) begin
                        return ID_W'(page_base + b);
                    end
                end
            end
        end
        return '0;
    endfunction

    // Apply one request to the shadow state and return the response it must produce.
    function automatic t_rsp apply_req(input t_req req);
        t_rsp rsp;
        rsp.granted_id = '0;
        case (req.action)
            ACT_PROPOSE: begin
                rsp.granted_id = find_free_id();
            end
            ACT_MARK: begin
                if (id_ok(req.target_id) && !used_flag[req.target_id]) begin
                    used_flag[req.target_id] = 1'b1;
                    used_total++;
                end
            end
            ACT_UNMARK: begin
                if (id_ok(req.target_id) && used_flag[req.target_id]) begin
                    used_flag[req.target_id] = 1'b0;
                    used_total--;
                end
            end
            default: begin
                foreach (used_flag[i]) begin
                    used_flag[i] = 1'b0;
                end
                used_total = 0;
            end
        endcase
        rsp.used_count = ID_W'(used_total);
        return rsp;
    endfunction

    // Present one request and hold it until the block takes it. Valid is raised only
    // at a falling edge, and a request that follows straight on keeps valid high.
    // Once the transfer happens, the expected response is queued.
    task automatic send_req(input t_req req, input logic typed, input t_rsp want);
        t_rsp pred;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        pred = apply_req(req);
        if (req.action == ACT_PROPOSE) begin
            last_grant = pred.granted_id;
        end
        rsp_due.push_back(typed ? want : pred);
    endtask

    task automatic send_op(input t_action action, input logic [ID_W-1:0] target_id);
        t_req req;
        req.action = action;
        req.target_id = target_id;
        send_req(req, 1'b0, '0);
    endtask

    // Drop valid and wait until every queued response has been seen. Each request
    // yields a response, so an empty queue means the block is idle.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rsp_due.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Seed writes happen only with the block idle. A zero seed loads one.
    task automatic write_seed(input logic [SEED_W-1:0] seed);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= seed;
        @(negedge clk);
        cfg_we <= 1'b0;
        draw_reg = (seed == '0) ? LFSR_RESET : seed;
    endtask

    // Mostly allocation traffic: a propose followed by a mark of the id it handed
    // out, and frees of ids handed out earlier. The rest is marks and unmarks of
    // arbitrary ids (id 0 included), bare proposes and an occasional clear.
    task automatic run_mixed(input int n_items);
        int sent;
        int pick;
        int slot;
        sent = 0;
        while (sent < n_items) begin
            // Now and then the sender holds off until the block has fully drained.
            if ($urandom_range(39) == 0) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_op(ACT_PROPOSE, ID_W'($urandom()));
                sent++;
                if (last_grant != '0 && $urandom_range(9) < 8) begin
                    send_op(ACT_MARK, last_grant);
                    held_ids.push_back(last_grant);
                    sent++;
                end
            end else if (pick < 60 && held_ids.size() != 0) begin
                slot = $urandom_range(held_ids.size() - 1);
                send_op(ACT_UNMARK, ID_W'(held_ids[slot]));
                held_ids.delete(slot);
                sent++;
            end else if (pick < 77) begin
                send_op(ACT_MARK, ID_W'($urandom()));
                sent++;
            end else if (pick < 94) begin
                send_op(ACT_UNMARK, ID_W'($urandom()));
                sent++;
            end else if (pick < 97) begin
                send_op(ACT_CLEAR, ID_W'($urandom()));
                held_ids.delete();
                sent++;
            end else begin
                send_op(ACT_PROPOSE, ID_W'($urandom()));
                sent++;
            end
        end
    endtask

    // Fill the store completely in a shuffled order. Near the end each mark is
    // preceded by a propose, so whole pages are full and the search has to draw
    // repeatedly. With the store full, propose must answer 0; freeing one id must
    // make propose find exactly that id.
    task automatic run_fill();
        int order[$];
        int i;
        int j;
        int tmp;
        int spare;
        send_op(ACT_CLEAR, ID_W'($urandom()));
        held_ids.delete();
        for (i = 1; i <= MAX_ID; i++) begin
            order.push_back(i);
        end
        for (i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < order.size(); i++) begin
            if (order.size() - i <= 48) begin
                send_op(ACT_PROPOSE, ID_W'($urandom()));
            end
            send_op(ACT_MARK, ID_W'(order[i]));
        end
        send_op(ACT_PROPOSE, ID_W'($urandom()));
        send_op(ACT_MARK, ID_W'(order[0]));
        spare = order[$urandom_range(MAX_ID - 1)];
        send_op(ACT_UNMARK, ID_W'(spare));
        send_op(ACT_PROPOSE, ID_W'($urandom()));
        send_op(ACT_MARK, last_grant);
        send_op(ACT_PROPOSE, ID_W'($urandom()));
        send_op(ACT_CLEAR, ID_W'($urandom()));
    endtask

    // Every response transfer is checked against the oldest expectation.
    always @(posedge clk) begin : rsp_check
        t_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (rsp_due.size() == 0) begin
                $error("response transfer with no request outstanding: granted_id %0d",
                       out_data.granted_id);
                fail_count++;
            end else begin
                want = rsp_due.pop_front();
                if (out_data.granted_id !== want.granted_id) begin
                    $error("granted_id: expected %0d, actual %0d",
                           want.granted_id, out_data.granted_id);
                    fail_count++;
                end
                if (out_data.used_count !== want.used_count) begin
                    $error("used_count: expected %0d, actual %0d",
                           want.used_count, out_data.used_count);
                    fail_count++;
                end
            end
        end
    end

    // The watchdog restarts on any transfer in either direction.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[random_probe_bitmap_id_allocator] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        t_req req;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows, starting from the reset seed and an empty store.
        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].reseed) begin
                write_seed(dir_rows[k].seed);
            end
            req.action = dir_rows[k].action;
            req.target_id = dir_rows[k].target_id;
            send_req(req, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases, each under its own seed and idling pattern.
        write_seed(16'hFFFF);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        run_mixed(60);

        write_seed(16'h0000);
        send_idle_pct = 75;
        recv_stall_pct = 0;
        run_mixed(60);

        write_seed(SEED_W'($urandom_range(65535, 1)));
        send_idle_pct = 0;
        recv_stall_pct = 75;
        run_mixed(60);

        write_seed(16'h0001);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_mixed(60);

        write_seed(SEED_W'($urandom_range(65535, 1)));
        send_idle_pct = 22;
        recv_stall_pct = 22;
        run_fill();

        // Let everything drain, then watch a little longer for stray responses.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("[random_probe_bitmap_id_allocator] OK");
        end else begin
            $display("[random_probe_bitmap_id_allocator] ERROR");
        end
        $finish;
    end

endmodule
